[hdl/clpg_pkg.sv]
// Shared types and constants of the clipped line pixel generator.
`timescale 1ns / 1ps
package clpg_pkg;

   // Field widths that do not vary.
   localparam int PITCH_BITS = 14;
   localparam int ADDR_BITS  = 32;
   localparam int COLOR_BITS = 32;
   localparam int CSR_BITS   = 32;
   localparam int CSR_INDEX_BITS = 2;

   // Register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_BASE   = 2'd3;

   // Outcode bits.
   localparam logic [3:0] OC_LEFT   = 4'b0001;
   localparam logic [3:0] OC_RIGHT  = 4'b0010;
   localparam logic [3:0] OC_TOP    = 4'b0100;
   localparam logic [3:0] OC_BOTTOM = 4'b1000;

   // Clip phases, in the order they are applied.
   localparam int PHASE_BITS = 3;
   localparam logic [PHASE_BITS-1:0] PH_LEFT   = 3'd0;
   localparam logic [PHASE_BITS-1:0] PH_RIGHT  = 3'd1;
   localparam logic [PHASE_BITS-1:0] PH_YREJ   = 3'd2;
   localparam logic [PHASE_BITS-1:0] PH_TOP    = 3'd3;
   localparam logic [PHASE_BITS-1:0] PH_BOTTOM = 3'd4;

   // Pixels emitted per accepted transfer before the line is parked.
   localparam int BURST_LEN  = 64;
   localparam int BURST_BITS = $clog2(BURST_LEN);

   typedef struct packed {
      logic                  load_item;
      logic [PHASE_BITS-1:0] phase;
      logic                  mul_load;
      logic                  div_start;
      logic                  clip_write;
      logic                  bres_setup;
      logic                  pix_load;
      logic                  resume;
   } clpg_cmd_type;

   typedef struct packed {
      logic empty_window;
      logic accept_all;
      logic reject;
      logic phase_active;
      logic y_reject;
      logic div_done;
      logic drawing;
      logic last_pixel;
      logic out_free;
   } clpg_status_type;

endpackage

[hdl/clipped_line_pixel_generator.sv]
// Top level of the clipped line pixel generator.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake          | Carries
//  req_    | in        | req_valid/stall    | two signed endpoints and a colour
//  rsp_    | out       | rsp_valid/stall    | pixel x, y, address, colour, last
//  csr_    | in        | csr_write          | frame width, height, pitch, base
//
//  A line that needs no clipping goes from its transfer through the check and
//  setup states to emission. A clipped line walks the five clip phases in
//  order unless the y reject phase drops it; each active phase adds a clip
//  division (CW is the internal coordinate width, 18 at the defaults), and up
//  to four divisions run one after another on the shared restoring divider.
//  Pixels then leave at one per cycle while rsp_stall is low.
//  Reset is synchronous and active high; it returns the block to idle and the
//  registers to 640 x 480, pitch 2560, base 0. req_stall is high whenever the
//  controller is not idle, so it is low while a line is parked; at most 64
//  pixels follow one transfer, and a transfer taken while a line is still
//  parked is dropped and releases the next 64 pixels of that line.
//
module clipped_line_pixel_generator #(
   parameter int COORD_BITS = 16,
   parameter int DIM_BITS   = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [COORD_BITS-1:0]        req_start_x,
   input  logic signed [COORD_BITS-1:0]        req_start_y,
   input  logic signed [COORD_BITS-1:0]        req_end_x,
   input  logic signed [COORD_BITS-1:0]        req_end_y,
   input  logic [clpg_pkg::COLOR_BITS-1:0]     req_line_color,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [DIM_BITS-1:0]                 rsp_pixel_x,
   output logic [DIM_BITS-1:0]                 rsp_pixel_y,
   output logic [clpg_pkg::ADDR_BITS-1:0]      rsp_pixel_address,
   output logic [clpg_pkg::COLOR_BITS-1:0]     rsp_pixel_value,
   output logic                                rsp_last_pixel,
   input  logic                                csr_write,
   input  logic [clpg_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [clpg_pkg::CSR_BITS-1:0]       csr_data
);

   clpg_pkg::clpg_cmd_type    cmd;
   clpg_pkg::clpg_status_type status;

   // Sequencer: decides what the datapath does each cycle
   clpg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Arithmetic, registers and the output stage
   clpg_datapath #(
      .COORD_BITS (COORD_BITS),
      .DIM_BITS   (DIM_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_line_color    (req_line_color),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

[hdl/clpg_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module clpg_divider #(
   parameter int NUM_BITS = 36,
   parameter int DEN_BITS = 18
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] dividend,
   input  logic [DEN_BITS-1:0] divisor,
   output logic [NUM_BITS-1:0] quotient,
   output logic [DEN_BITS-1:0] remainder,
   output logic                done
);

   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quo_ff, quo_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;
   logic                fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_BITS-1]};
      fits   = trial >= {1'b0, den_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_BITS-2:0], fits};
         rem_in = fits ? DEN_BITS'(trial - {1'b0, den_ff}) : trial[DEN_BITS-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

[hdl/clpg_datapath.sv]
// Datapath: endpoints, clip arithmetic, Bresenham walker and output register.
`timescale 1ns / 1ps
module clpg_datapath #(
   parameter int COORD_BITS = 16,
   parameter int DIM_BITS   = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  clpg_pkg::clpg_cmd_type                cmd,
   output clpg_pkg::clpg_status_type             status,
   input  logic                                  csr_write,
   input  logic [clpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [clpg_pkg::CSR_BITS-1:0]         csr_data,
   input  logic signed [COORD_BITS-1:0]          req_start_x,
   input  logic signed [COORD_BITS-1:0]          req_start_y,
   input  logic signed [COORD_BITS-1:0]          req_end_x,
   input  logic signed [COORD_BITS-1:0]          req_end_y,
   input  logic [clpg_pkg::COLOR_BITS-1:0]       req_line_color,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [DIM_BITS-1:0]                   rsp_pixel_x,
   output logic [DIM_BITS-1:0]                   rsp_pixel_y,
   output logic [clpg_pkg::ADDR_BITS-1:0]        rsp_pixel_address,
   output logic [clpg_pkg::COLOR_BITS-1:0]       rsp_pixel_value,
   output logic                                  rsp_last_pixel
);

   localparam int CW = ((COORD_BITS > DIM_BITS + 1) ? COORD_BITS : DIM_BITS + 1) + 2;
   localparam int PW = 2 * CW;
   localparam int EW = DIM_BITS + 2;

   // Configuration registers
   logic [DIM_BITS-1:0]             width_ff, height_ff;
   logic [clpg_pkg::PITCH_BITS-1:0] pitch_ff;
   logic [clpg_pkg::ADDR_BITS-1:0]  base_ff;

   // Endpoints under clipping
   logic signed [CW-1:0] x0_ff, y0_ff, x1_ff, y1_ff;
   logic signed [CW-1:0] x0_in, y0_in, x1_in, y1_in;
   logic [clpg_pkg::COLOR_BITS-1:0] color_ff;

   // Interpolation operands
   logic signed [CW-1:0] wext, hext, tgt, c0, c1, t0, t1, ce, co, te, to_c;
   logic signed [CW-1:0] xe, ye, xo, yo, diff_a, diff_b, diff_d;
   logic [CW-1:0]        mag_a, mag_b, mag_d;
   logic                 sel_e, ax_y, pat_b, active;
   logic [3:0]           code0, code1;

   logic [PW-1:0]        prod_ff;
   logic [CW-1:0]        den_ff;
   logic signed [CW-1:0] c0_ff;
   logic                 neg_ff, dzero_ff;

   logic [PW-1:0]        quot;
   logic [CW-1:0]        rem;
   logic                 div_done;
   logic signed [CW-1:0] qs, base, res;
   logic [CW-1:0]        nrem;
   logic [CW:0]          twice_n;

   // Bresenham state
   logic [DIM_BITS-1:0]  cur_x_ff, cur_y_ff, stop_x_ff, stop_y_ff, dx_ff, dy_ff;
   logic signed [EW-1:0] err_ff;
   logic                 dxn_ff, dyn_ff, drawing_ff;
   logic [DIM_BITS-1:0]  sx0, sy0, sx1, sy1, sdx, sdy;
   logic signed [EW-1:0] e_dx, e_dy;
   logic                 step_x, step_y, last;

   // Output register
   logic                            out_valid_ff;
   logic [DIM_BITS-1:0]             out_x_ff, out_y_ff;
   logic [clpg_pkg::ADDR_BITS-1:0]  out_addr_ff;
   logic [clpg_pkg::COLOR_BITS-1:0] out_value_ff;
   logic                            out_last_ff;
   logic [clpg_pkg::ADDR_BITS-1:0]  addr_calc;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_BITS'(640);
         height_ff <= DIM_BITS'(480);
         pitch_ff  <= clpg_pkg::PITCH_BITS'(2560);
         base_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            clpg_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_data[DIM_BITS-1:0];
            clpg_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_data[DIM_BITS-1:0];
            clpg_pkg::CSR_ROW_PITCH:    pitch_ff  <= csr_data[clpg_pkg::PITCH_BITS-1:0];
            clpg_pkg::CSR_FRAME_BASE:   base_ff   <= csr_data[clpg_pkg::ADDR_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign wext = signed'({{(CW-DIM_BITS){1'b0}}, width_ff});
   assign hext = signed'({{(CW-DIM_BITS){1'b0}}, height_ff});

   // Outcodes of the loaded endpoints
   always_comb begin
      code0 = '0;
      code1 = '0;
      if (x0_ff < 0)     code0 = code0 | clpg_pkg::OC_LEFT;
      if (x0_ff >= wext) code0 = code0 | clpg_pkg::OC_RIGHT;
      if (y0_ff < 0)     code0 = code0 | clpg_pkg::OC_TOP;
      if (y0_ff >= hext) code0 = code0 | clpg_pkg::OC_BOTTOM;
      if (x1_ff < 0)     code1 = code1 | clpg_pkg::OC_LEFT;
      if (x1_ff >= wext) code1 = code1 | clpg_pkg::OC_RIGHT;
      if (y1_ff < 0)     code1 = code1 | clpg_pkg::OC_TOP;
      if (y1_ff >= hext) code1 = code1 | clpg_pkg::OC_BOTTOM;
   end

   // Pick the endpoint moved in this phase and the interpolation operands
   always_comb begin
      active = 1'b0;
      sel_e  = 1'b0;
      ax_y   = 1'b0;
      pat_b  = 1'b0;
      tgt    = '0;
      case (cmd.phase)
         clpg_pkg::PH_LEFT: begin
            active = (x0_ff < 0) || (x1_ff < 0);
            sel_e  = !(x0_ff < 0);
         end
         clpg_pkg::PH_RIGHT: begin
            active = (x0_ff >= wext) || (x1_ff >= wext);
            sel_e  = !(x0_ff >= wext);
            pat_b  = 1'b1;
            tgt    = wext - 1'b1;
         end
         clpg_pkg::PH_TOP: begin
            active = (y0_ff < 0) || (y1_ff < 0);
            sel_e  = !(y0_ff < 0);
            ax_y   = 1'b1;
         end
         clpg_pkg::PH_BOTTOM: begin
            active = (y0_ff >= hext) || (y1_ff >= hext);
            sel_e  = !(y0_ff >= hext);
            ax_y   = 1'b1;
            pat_b  = 1'b1;
            tgt    = hext - 1'b1;
         end
         default: ;
      endcase
      xe   = sel_e ? x1_ff : x0_ff;
      ye   = sel_e ? y1_ff : y0_ff;
      xo   = sel_e ? x0_ff : x1_ff;
      yo   = sel_e ? y0_ff : y1_ff;
      ce   = ax_y ? xe : ye;
      co   = ax_y ? xo : yo;
      te   = ax_y ? ye : xe;
      to_c = ax_y ? yo : xo;
      c0   = pat_b ? co : ce;
      c1   = pat_b ? ce : co;
      t0   = pat_b ? to_c : te;
      t1   = pat_b ? te : to_c;
      diff_a = tgt - t0;
      diff_b = c1 - c0;
      diff_d = t1 - t0;
      mag_a  = diff_a < 0 ? CW'(-diff_a) : CW'(diff_a);
      mag_b  = diff_b < 0 ? CW'(-diff_b) : CW'(diff_b);
      mag_d  = diff_d < 0 ? CW'(-diff_d) : CW'(diff_d);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_ff  <= PW'(mag_a * mag_b);
         den_ff   <= mag_d;
         c0_ff    <= c0;
         neg_ff   <= (diff_a < 0) ^ (diff_b < 0) ^ (diff_d < 0);
         dzero_ff <= (diff_d == 0);
      end
   end

   clpg_divider #(
      .NUM_BITS (PW),
      .DEN_BITS (CW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (prod_ff),
      .divisor   (den_ff),
      .quotient  (quot),
      .remainder (rem),
      .done      (div_done)
   );

   // Round the quotient half away from zero
   always_comb begin
      qs = signed'(quot[CW-1:0]);
      if (!neg_ff) begin
         base = c0_ff + qs;
         nrem = rem;
      end else if (rem == '0) begin
         base = c0_ff - qs;
         nrem = '0;
      end else begin
         base = c0_ff - qs - 1'b1;
         nrem = den_ff - rem;
      end
      twice_n = {nrem, 1'b0};
      if (twice_n > {1'b0, den_ff}) begin
         res = base + 1'b1;
      end else if (twice_n < {1'b0, den_ff}) begin
         res = base;
      end else begin
         res = (base >= 0) ? base + 1'b1 : base;
      end
      if (dzero_ff) res = c0_ff;
   end

   always_comb begin
      x0_in = x0_ff;
      y0_in = y0_ff;
      x1_in = x1_ff;
      y1_in = y1_ff;
      if (cmd.load_item) begin
         x0_in = CW'(req_start_x);
         y0_in = CW'(req_start_y);
         x1_in = CW'(req_end_x);
         y1_in = CW'(req_end_y);
      end else if (cmd.clip_write) begin
         if (ax_y) begin
            if (sel_e) begin
               x1_in = res;
               y1_in = tgt;
            end else begin
               x0_in = res;
               y0_in = tgt;
            end
         end else begin
            if (sel_e) begin
               y1_in = res;
               x1_in = tgt;
            end else begin
               y0_in = res;
               x0_in = tgt;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      x0_ff <= x0_in;
      y0_ff <= y0_in;
      x1_ff <= x1_in;
      y1_ff <= y1_in;
      if (cmd.load_item) color_ff <= req_line_color;
   end

   // Bresenham setup and step
   always_comb begin
      sx0  = x0_ff[DIM_BITS-1:0];
      sy0  = y0_ff[DIM_BITS-1:0];
      sx1  = x1_ff[DIM_BITS-1:0];
      sy1  = y1_ff[DIM_BITS-1:0];
      sdx  = (sx1 >= sx0) ? sx1 - sx0 : sx0 - sx1;
      sdy  = (sy1 >= sy0) ? sy1 - sy0 : sy0 - sy1;
      e_dx = signed'({2'b00, dx_ff});
      e_dy = signed'({2'b00, dy_ff});
      step_x = err_ff > -e_dx;
      step_y = err_ff < e_dy;
      last   = (cur_x_ff == stop_x_ff) && (cur_y_ff == stop_y_ff);
      addr_calc = base_ff
                + clpg_pkg::ADDR_BITS'(cur_y_ff * pitch_ff)
                + clpg_pkg::ADDR_BITS'({cur_x_ff, 2'b00});
   end

   always_ff @(posedge clock) begin
      if (cmd.bres_setup) begin
         cur_x_ff  <= sx0;
         cur_y_ff  <= sy0;
         stop_x_ff <= sx1;
         stop_y_ff <= sy1;
         dx_ff     <= sdx;
         dy_ff     <= sdy;
         dxn_ff    <= !(sx0 < sx1);
         dyn_ff    <= !(sy0 < sy1);
         err_ff    <= (sdx > sdy) ? signed'(EW'(sdx >> 1)) : -signed'(EW'(sdy >> 1));
      end else if (cmd.pix_load && !last) begin
         err_ff <= err_ff - (step_x ? e_dy : EW'(0)) + (step_y ? e_dx : EW'(0));
         if (step_x) cur_x_ff <= dxn_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         if (step_y) cur_y_ff <= dyn_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
      end
      if (cmd.pix_load) begin
         out_x_ff     <= cur_x_ff;
         out_y_ff     <= cur_y_ff;
         out_addr_ff  <= addr_calc;
         out_value_ff <= color_ff;
         out_last_ff  <= last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drawing_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.bres_setup) begin
            drawing_ff <= 1'b1;
         end else if (cmd.pix_load && last) begin
            drawing_ff <= 1'b0;
         end
         if (cmd.pix_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_comb begin
      status.empty_window = (width_ff == '0) || (height_ff == '0);
      status.accept_all   = (code0 | code1) == 4'b0000;
      status.reject       = (code0 & code1) != 4'b0000;
      status.phase_active = active;
      status.y_reject     = ((y0_ff < 0) && (y1_ff < 0)) ||
                            ((y0_ff >= hext) && (y1_ff >= hext));
      status.div_done     = div_done;
      status.drawing      = drawing_ff;
      status.last_pixel   = last;
      status.out_free     = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_pixel_x       = out_x_ff;
   assign rsp_pixel_y       = out_y_ff;
   assign rsp_pixel_address = out_addr_ff;
   assign rsp_pixel_value   = out_value_ff;
   assign rsp_last_pixel    = out_last_ff;

endmodule

[hdl/clpg_ctrl.sv]
// Controller: sequences loading, clip phases, division and pixel emission.
`timescale 1ns / 1ps
module clpg_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output clpg_pkg::clpg_cmd_type    cmd,
   input  clpg_pkg::clpg_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_PHASE = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_WRITE = 3'd5;
   localparam logic [2:0] ST_SETUP = 3'd6;
   localparam logic [2:0] ST_EMIT  = 3'd7;

   logic [2:0]                          state_ff, state_in;
   logic [clpg_pkg::PHASE_BITS-1:0]     phase_ff, phase_in;
   logic [clpg_pkg::BURST_BITS-1:0]     cnt_ff, cnt_in;
   logic                                accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.phase = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in = '0;
               if (status.drawing) begin
                  // drop the item, carry on with the parked line
                  cmd.resume = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  cmd.load_item = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (status.empty_window || status.reject) begin
               state_in = ST_IDLE;
            end else if (status.accept_all) begin
               state_in = ST_SETUP;
            end else begin
               phase_in = clpg_pkg::PH_LEFT;
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            if (phase_ff == clpg_pkg::PH_YREJ) begin
               if (status.y_reject) begin
                  state_in = ST_IDLE;
               end else begin
                  phase_in = clpg_pkg::PH_TOP;
               end
            end else if (status.phase_active) begin
               cmd.mul_load = 1'b1;
               state_in = ST_MUL;
            end else if (phase_ff == clpg_pkg::PH_BOTTOM) begin
               state_in = ST_SETUP;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_MUL: begin
            cmd.div_start = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.clip_write = 1'b1;
            if (phase_ff == clpg_pkg::PH_BOTTOM) begin
               state_in = ST_SETUP;
            end else begin
               phase_in = phase_ff + 1'b1;
               state_in = ST_PHASE;
            end
         end
         ST_SETUP: begin
            cmd.bres_setup = 1'b1;
            cnt_in = '0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.pix_load = 1'b1;
               cnt_in = cnt_ff + 1'b1;
               if (status.last_pixel ||
                   cnt_ff == clpg_pkg::BURST_BITS'(clpg_pkg::BURST_LEN - 1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      phase_ff <= phase_in;
      cnt_ff   <= cnt_in;
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
